// ===== hdl/awsh_pkg.sv =====
package awsh_pkg;

   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC      = 11;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REG_IDX_BITS   = 2;

   localparam logic [REG_IDX_BITS-1:0] REG_SHAPE_MODE  = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_INPUT_GAIN  = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_OUTPUT_GAIN = 2'd2;

   typedef enum logic [2:0] {
      SHAPE_HARD = 3'd0,
      SHAPE_SOFT = 3'd1,
      SHAPE_EXP  = 3'd2,
      SHAPE_FULL = 3'd3,
      SHAPE_HALF = 3'd4
   } shape_mode_type;

   typedef struct packed {
      shape_mode_type         shape_mode;
      logic [GAIN_BITS-1:0]   input_gain;
      logic [GAIN_BITS-1:0]   output_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      shape_mode:  SHAPE_FULL,
      input_gain:  16'd8153,
      output_gain: 16'd129
   };

   // e^-(k*16/2^tbits) in Q1.32, built as r^k by square and multiply
   function automatic logic [32:0] exp_rom_entry(input int k, input int tbits);
      logic [63:0] term;
      logic [63:0] r;
      logic [63:0] res;
      logic [63:0] base;
      int          e;
      term = 64'd1 << 32;
      r    = term;
      for (int n = 1; n <= 24; n++) begin
         term = (term >> (tbits - 4)) / 64'(n);
         if (n[0]) begin
            r = r - term;
         end else begin
            r = r + term;
         end
      end
      res  = 64'd1 << 32;
      base = r;
      e    = k;
      while (e != 0) begin
         if (e[0]) begin
            res = (res * base + (64'd1 << 31)) >> 32;
         end
         base = (base * base + (64'd1 << 31)) >> 32;
         e    = e >> 1;
      end
      return res[32:0];
   endfunction

endpackage

// ===== hdl/awsh_csr.sv =====
module awsh_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [awsh_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [awsh_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [awsh_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output awsh_pkg::cfg_type                   cfg
);
   import awsh_pkg::*;

   cfg_type                  cfg_ff;
   logic [REG_IDX_BITS-1:0]  reg_idx;
   logic                     wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_SHAPE_MODE:  cfg_ff.shape_mode  <= shape_mode_type'(csr_pwdata[2:0]);
            REG_INPUT_GAIN:  cfg_ff.input_gain  <= csr_pwdata[GAIN_BITS-1:0];
            REG_OUTPUT_GAIN: cfg_ff.output_gain <= csr_pwdata[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SHAPE_MODE:  csr_prdata = CSR_DATA_BITS'(cfg_ff.shape_mode);
         REG_INPUT_GAIN:  csr_prdata = CSR_DATA_BITS'(cfg_ff.input_gain);
         REG_OUTPUT_GAIN: csr_prdata = CSR_DATA_BITS'(cfg_ff.output_gain);
         default:         csr_prdata = '0;
      endcase
   end

endmodule

// ===== hdl/awsh_gain.sv =====
module awsh_gain #(
   parameter int IN_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [IN_BITS-1:0]         in_data,
   input  logic [awsh_pkg::GAIN_BITS-1:0]    gain,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [IN_BITS+5:0]         out_data
);
   import awsh_pkg::*;

   localparam int PROD_BITS = IN_BITS + GAIN_BITS + 1;
   localparam int OUT_BITS  = IN_BITS + 6;
   localparam logic signed [PROD_BITS-1:0] HALF_LSB = PROD_BITS'(1) << (GAIN_FRAC - 1);

   logic [1:0]                   vld_ff;
   logic [1:0]                   en;
   logic signed [PROD_BITS-1:0]  prod_ff;
   logic signed [PROD_BITS-1:0]  prod_in;
   logic signed [PROD_BITS-1:0]  biased;
   logic signed [OUT_BITS-1:0]   res_ff;
   logic signed [OUT_BITS-1:0]   res_in;

   assign en[1] = !vld_ff[1] || out_ready;
   assign en[0] = !vld_ff[0] || en[1];

   // multiply, then round half up on the Q5.11 gain
   assign prod_in = PROD_BITS'(in_data) * PROD_BITS'($signed({1'b0, gain}));
   assign biased  = prod_ff + HALF_LSB;
   assign res_in  = OUT_BITS'(biased >>> GAIN_FRAC);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         if (en[1]) vld_ff[1] <= vld_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) prod_ff <= prod_in;
      if (en[1]) res_ff  <= res_in;
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[1];
   assign out_data  = res_ff;

endmodule

// ===== hdl/awsh_shaper.sv =====
module awsh_shaper #(
   parameter int SAMPLE_BITS    = 24,
   parameter int EXP_TABLE_BITS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  awsh_pkg::shape_mode_type        shape_mode,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [SAMPLE_BITS+5:0]   in_data,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [SAMPLE_BITS+5:0]   out_data
);
   import awsh_pkg::*;

   localparam int F  = SAMPLE_BITS - 1;
   localparam int VW = SAMPLE_BITS + 6;
   localparam int AW = VW + 2;
   localparam int T  = EXP_TABLE_BITS;
   localparam int N  = 2 ** T;
   localparam int SW = 2 * F;
   localparam int PW = 32 + F;
   localparam int K  = F + 2;
   localparam int NS = 4;

   localparam logic [AW-1:0]        ONE_A     = AW'(1) << F;
   localparam logic [AW-1:0]        TWO_A     = AW'(1) << (F + 1);
   localparam logic [VW-1:0]        SIXTEEN   = VW'(1) << (F + 4);
   localparam logic signed [VW-1:0] HALF_S    = VW'(1) << (F - 1);
   localparam logic signed [VW-1:0] ONE_S     = VW'(1) << F;
   localparam logic [SW:0]          THREE_ONE = (SW + 1)'(3) << F;
   localparam logic [F:0]           RECIP3    = (F + 1)'((64'(1) << K) / 3);
   localparam logic [32:0]          ROUND_E   = 33'(1) << (31 - F);
   localparam logic [F:0]           ONE_F     = (F + 1)'(1) << F;

   logic [32:0] exp_rom [N + 1];

   for (genvar k = 0; k <= N; k++) begin : g_rom
      localparam logic [32:0] ENTRY = exp_rom_entry(k, EXP_TABLE_BITS);
      assign exp_rom[k] = ENTRY;
   end

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k + 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) vld_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) begin
            if (en[k]) vld_ff[k] <= vld_ff[k - 1];
         end
      end
   end

   // stage 1: magnitude, simple shapes, soft-clip region, table lookup
   logic                    neg;
   logic [VW-1:0]           mag;
   logic [AW-1:0]           mag3;
   logic                    soft_sat;
   logic                    soft_mid;
   logic [F-1:0]            u_in;
   logic signed [VW-1:0]    hard_v;
   logic signed [VW-1:0]    simple_in;
   logic [T-1:0]            idx;
   logic [T:0]              idx_next;
   logic [32:0]             e0_in;
   logic [32:0]             e1;
   logic [31:0]             diff_in;
   logic [F-1:0]            frac_in;

   assign neg      = in_data[VW-1];
   assign mag      = neg ? $unsigned(-in_data) : $unsigned(in_data);
   assign mag3     = AW'(mag) + (AW'(mag) << 1);
   assign soft_sat = mag3 > TWO_A;
   assign soft_mid = !soft_sat && (mag3 > ONE_A);
   assign u_in     = F'(TWO_A - mag3);
   assign hard_v   = (in_data > HALF_S) ? HALF_S :
                     ((in_data < -HALF_S) ? -HALF_S : in_data);
   assign idx      = mag[F+3 -: T];
   assign idx_next = (T + 1)'(idx) + (T + 1)'(1);
   assign e0_in    = exp_rom[{1'b0, idx}];
   assign e1       = exp_rom[idx_next];
   assign diff_in  = 32'(e0_in - e1);
   assign frac_in  = {mag[F-T+3:0], {(T - 4){1'b0}}};

   always_comb begin
      case (shape_mode)
         SHAPE_HARD: simple_in = hard_v;
         SHAPE_FULL: simple_in = $signed(mag);
         SHAPE_HALF: simple_in = (in_data > 0) ? in_data : '0;
         default:    simple_in = '0;
      endcase
   end

   logic signed [VW-1:0]  s1_v_ff;
   logic signed [VW-1:0]  s1_simple_ff;
   logic                  s1_neg_ff;
   logic                  s1_sat_ff;
   logic                  s1_mid_ff;
   logic [F-1:0]          s1_u_ff;
   logic                  s1_big_ff;
   logic                  s1_zero_ff;
   logic [32:0]           s1_e0_ff;
   logic [31:0]           s1_diff_ff;
   logic [F-1:0]          s1_frac_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_v_ff      <= in_data;
         s1_simple_ff <= simple_in;
         s1_neg_ff    <= neg;
         s1_sat_ff    <= soft_sat;
         s1_mid_ff    <= soft_mid;
         s1_u_ff      <= u_in;
         s1_big_ff    <= mag >= SIXTEEN;
         s1_zero_ff   <= in_data == '0;
         s1_e0_ff     <= e0_in;
         s1_diff_ff   <= diff_in;
         s1_frac_ff   <= frac_in;
      end
   end

   // stage 2: square for soft clip, interpolation product
   logic signed [VW-1:0]  s2_v_ff;
   logic signed [VW-1:0]  s2_simple_ff;
   logic                  s2_neg_ff;
   logic                  s2_sat_ff;
   logic                  s2_mid_ff;
   logic                  s2_big_ff;
   logic                  s2_zero_ff;
   logic [32:0]           s2_e0_ff;
   logic [SW-1:0]         s2_sq_ff;
   logic [PW-1:0]         s2_pe_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_v_ff      <= s1_v_ff;
         s2_simple_ff <= s1_simple_ff;
         s2_neg_ff    <= s1_neg_ff;
         s2_sat_ff    <= s1_sat_ff;
         s2_mid_ff    <= s1_mid_ff;
         s2_big_ff    <= s1_big_ff;
         s2_zero_ff   <= s1_zero_ff;
         s2_e0_ff     <= s1_e0_ff;
         s2_sq_ff     <= SW'(s1_u_ff) * SW'(s1_u_ff);
         s2_pe_ff     <= PW'(s1_diff_ff) * PW'(s1_frac_ff);
      end
   end

   // stage 3: divide by 3 estimate, finish exponential
   logic [SW:0]           q_sum;
   logic [F-1:0]          q_in;
   logic [SW:0]           q_prod;
   logic [F-1:0]          qd_in;
   logic [32:0]           e_val;
   logic [F:0]            ef;
   logic [F:0]            exp_mag;
   logic signed [VW-1:0]  exp_abs;
   logic signed [VW-1:0]  exp_in;

   assign q_sum   = (SW + 1)'(s2_sq_ff) + THREE_ONE;
   assign q_in    = F'(q_sum >> (F + 1));
   assign q_prod  = (SW + 1)'(q_in) * (SW + 1)'(RECIP3);
   assign qd_in   = F'(q_prod >> K);
   assign e_val   = s2_e0_ff - 33'(s2_pe_ff >> F);
   assign ef      = (F + 1)'((e_val + ROUND_E) >> (32 - F));
   assign exp_mag = ONE_F - ef;
   assign exp_abs = s2_big_ff ? ONE_S : $signed(VW'(exp_mag));
   assign exp_in  = s2_zero_ff ? '0 : (s2_neg_ff ? -exp_abs : exp_abs);

   logic signed [VW-1:0]  s3_v_ff;
   logic signed [VW-1:0]  s3_simple_ff;
   logic                  s3_neg_ff;
   logic                  s3_sat_ff;
   logic                  s3_mid_ff;
   logic [F-1:0]          s3_q_ff;
   logic [F-1:0]          s3_qd_ff;
   logic signed [VW-1:0]  s3_exp_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_v_ff      <= s2_v_ff;
         s3_simple_ff <= s2_simple_ff;
         s3_neg_ff    <= s2_neg_ff;
         s3_sat_ff    <= s2_sat_ff;
         s3_mid_ff    <= s2_mid_ff;
         s3_q_ff      <= q_in;
         s3_qd_ff     <= qd_in;
         s3_exp_ff    <= exp_in;
      end
   end

   // stage 4: quotient correction, soft-clip result, mode select
   logic [F+1:0]          rem;
   logic [F-1:0]          term;
   logic signed [VW-1:0]  term_s;
   logic signed [VW-1:0]  soft_v;
   logic signed [VW-1:0]  shaped_in;
   logic signed [VW-1:0]  shaped_ff;

   assign rem    = (F + 2)'(s3_q_ff) - ((F + 2)'(s3_qd_ff) + ((F + 2)'(s3_qd_ff) << 1));
   assign term   = s3_qd_ff + F'(rem >= (F + 2)'(3));
   assign term_s = $signed(VW'(term));

   always_comb begin
      if (s3_mid_ff) begin
         soft_v = s3_neg_ff ? (term_s - HALF_S) : (HALF_S - term_s);
      end else if (s3_sat_ff) begin
         soft_v = s3_neg_ff ? -HALF_S : HALF_S;
      end else begin
         soft_v = s3_v_ff;
      end
   end

   always_comb begin
      case (shape_mode)
         SHAPE_SOFT: shaped_in = soft_v;
         SHAPE_EXP:  shaped_in = s3_exp_ff;
         default:    shaped_in = s3_simple_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[3]) shaped_ff <= shaped_in;
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NS-1];
   assign out_data  = shaped_ff;

endmodule

// ===== hdl/awsh_sat.sv =====
module awsh_sat #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [SAMPLE_BITS+11:0]   in_data,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [SAMPLE_BITS-1:0]    out_data,
   output logic                             out_clipped
);
   localparam int IN_BITS = SAMPLE_BITS + 12;
   localparam logic signed [IN_BITS-1:0] MAX_S =
      IN_BITS'((64'(1) << (SAMPLE_BITS - 1)) - 64'(1));
   localparam logic signed [IN_BITS-1:0] MIN_S = ~MAX_S;

   logic                           vld_ff;
   logic                           en;
   logic signed [SAMPLE_BITS-1:0]  data_ff;
   logic signed [SAMPLE_BITS-1:0]  data_in;
   logic                           clip_ff;
   logic                           clip_in;

   assign en = !vld_ff || out_ready;

   always_comb begin
      if (in_data > MAX_S) begin
         data_in = SAMPLE_BITS'(MAX_S);
         clip_in = 1'b1;
      end else if (in_data < MIN_S) begin
         data_in = SAMPLE_BITS'(MIN_S);
         clip_in = 1'b1;
      end else begin
         data_in = SAMPLE_BITS'(in_data);
         clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
         clip_ff <= clip_in;
      end
   end

   assign in_ready    = en;
   assign out_valid   = vld_ff;
   assign out_data    = data_ff;
   assign out_clipped = clip_ff;

endmodule

// ===== hdl/audio_distortion_waveshaper.sv =====
// Channel | Dir | Beat content
// req_*   | in  | tdata: sample_in (signed Q1.23), upper pad bits ignored
// rsp_*   | out | tdata: sample_out (signed Q1.23, saturated); tuser: clipped
// csr_*   | in  | APB: 0x0 shape_mode, 0x4 input_gain, 0x8 output_gain
//
// One beat per cycle sustained while rsp_tready is high; the req-to-rsp
// path passes the two gain multiplier stages (2 each), the shaper
// (table lookup, squaring/interpolation product, divide-by-3 estimate,
// correction and select) and the output saturation register.
// Synchronous reset clears all stage valids and loads register defaults.
// Each stage holds on rsp_tready low; bubbles close up, nothing repeats.
module audio_distortion_waveshaper #(
   parameter int SAMPLE_BITS    = 24,
   parameter int EXP_TABLE_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]  req_tdata,  // sample_in
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0]  rsp_tdata,  // sample_out
   output logic                                    rsp_tuser,  // clipped
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [awsh_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [awsh_pkg::CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [awsh_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                                    csr_pready
);
   import awsh_pkg::*;

   localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int VW     = SAMPLE_BITS + 6;
   localparam int YW     = SAMPLE_BITS + 12;

   cfg_type                        cfg;
   logic                           v_valid;
   logic                           v_ready;
   logic signed [VW-1:0]           v_data;
   logic                           s_valid;
   logic                           s_ready;
   logic signed [VW-1:0]           s_data;
   logic                           y_valid;
   logic                           y_ready;
   logic signed [YW-1:0]           y_data;
   logic signed [SAMPLE_BITS-1:0]  sample_out;

   awsh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   awsh_gain #(.IN_BITS(SAMPLE_BITS)) u_in_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .gain      (cfg.input_gain),
      .out_valid (v_valid),
      .out_ready (v_ready),
      .out_data  (v_data)
   );

   awsh_shaper #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .EXP_TABLE_BITS (EXP_TABLE_BITS)
   ) u_shaper (
      .clock      (clock),
      .reset      (reset),
      .shape_mode (cfg.shape_mode),
      .in_valid   (v_valid),
      .in_ready   (v_ready),
      .in_data    (v_data),
      .out_valid  (s_valid),
      .out_ready  (s_ready),
      .out_data   (s_data)
   );

   awsh_gain #(.IN_BITS(VW)) u_out_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_data   (s_data),
      .gain      (cfg.output_gain),
      .out_valid (y_valid),
      .out_ready (y_ready),
      .out_data  (y_data)
   );

   awsh_sat #(.SAMPLE_BITS(SAMPLE_BITS)) u_sat (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (y_valid),
      .in_ready    (y_ready),
      .in_data     (y_data),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (sample_out),
      .out_clipped (rsp_tuser)
   );

   assign rsp_tdata = DATA_W'($unsigned(sample_out));

endmodule
